// ===== hdl/tilt_complementary_estimator_unit_assert.svh =====
// Assertion macros used by the tilt estimator checker.
`ifndef TILT_COMPLEMENTARY_ESTIMATOR_UNIT_ASSERT_SVH
`define TILT_COMPLEMENTARY_ESTIMATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tce: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tce: next-cycle check failed");

`endif

// ===== hdl/tce_pkg.sv =====
// Shared types, constants and helper functions of the tilt estimator.
package tce_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int COUNT_WIDTH_DEF   = 32;

  localparam int MUL_W     = 34;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIV_NUM_W = 44;
  localparam int DIV_DEN_W = 10;

  localparam logic signed [32:0] ANGLE_PI = 33'sd843314857;

  localparam logic [31:0] GYRO_SCALE_RST      = 32'd571914;
  localparam logic [31:0] SAMPLE_PERIOD_RST   = 32'd17179869;
  localparam logic [15:0] FUSE_WEIGHT_RST     = 16'd64225;
  localparam logic [9:0]  CALIB_SAMPLES_RST   = 10'd600;
  localparam logic [7:0]  VELOCITY_WINDOW_RST = 8'd25;

  typedef enum logic [2:0] {
    REG_GYRO_SCALE      = 3'd0,
    REG_SAMPLE_PERIOD   = 3'd1,
    REG_FUSE_WEIGHT     = 3'd2,
    REG_CALIB_SAMPLES   = 3'd3,
    REG_VELOCITY_WINDOW = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_CAL_MUL,
    ST_CAL_DIV,
    ST_CAL_WAIT1,
    ST_CAL_WAIT2,
    ST_CORR,
    ST_STEP,
    ST_FUSE,
    ST_FINISH
  } seq_state_e;

  // round(atan(2^-i) * 2^28)
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd210828714;
      5'd1:  v = 32'd124459457;
      5'd2:  v = 32'd65760959;
      5'd3:  v = 32'd33381290;
      5'd4:  v = 32'd16755422;
      5'd5:  v = 32'd8385879;
      5'd6:  v = 32'd4193963;
      5'd7:  v = 32'd2097109;
      5'd8:  v = 32'd1048571;
      5'd9:  v = 32'd524287;
      5'd10: v = 32'd262144;
      5'd11: v = 32'd131072;
      5'd12: v = 32'd65536;
      5'd13: v = 32'd32768;
      5'd14: v = 32'd16384;
      5'd15: v = 32'd8192;
      5'd16: v = 32'd4096;
      5'd17: v = 32'd2048;
      5'd18: v = 32'd1024;
      5'd19: v = 32'd512;
      5'd20: v = 32'd256;
      5'd21: v = 32'd128;
      5'd22: v = 32'd64;
      5'd23: v = 32'd32;
      5'd24: v = 32'd16;
      5'd25: v = 32'd8;
      5'd26: v = 32'd4;
      5'd27: v = 32'd2;
      5'd28: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/tce_cordic.sv =====
// Iterative vectoring CORDIC: one micro-rotation per cycle, gives atan2(y, x) in Q4.28.
module tce_cordic
  import tce_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [16:0] y_i,
  input  logic signed [16:0] x_i,
  output logic               done_o,
  output logic signed [32:0] angle_o
);

  localparam int IW = $clog2(STAGES);

  logic signed [35:0] x_q, y_q, x_d, y_d;
  logic signed [32:0] z_q, z_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic               busy_q, busy_d, done_q, done_d, zero_q, zero_d;
  logic signed [35:0] xs, ys, x_sh, y_sh;
  logic signed [32:0] atan_v;

  always_comb begin
    xs     = 36'(x_i) <<< 16;
    ys     = 36'(y_i) <<< 16;
    x_sh   = x_q >>> idx_q;
    y_sh   = y_q >>> idx_q;
    atan_v = $signed({1'b0, atan_lut(5'(idx_q))});
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    done_d = 1'b0;
    zero_d = zero_q;
    if (start_i) begin
      zero_d = (x_i == 17'sd0) && (y_i == 17'sd0);
      idx_d  = '0;
      busy_d = 1'b1;
      // mirror the left half-plane into the right
      if (xs < 36'sd0) begin
        z_d = (ys >= 36'sd0) ? ANGLE_PI : -ANGLE_PI;
        x_d = -xs;
        y_d = -ys;
      end else begin
        z_d = '0;
        x_d = xs;
        y_d = ys;
      end
    end else if (busy_q) begin
      if (y_q > 36'sd0) begin
        x_d = x_q + y_sh;
        y_d = y_q - x_sh;
        z_d = z_q + atan_v;
      end else begin
        x_d = x_q - y_sh;
        y_d = y_q + x_sh;
        z_d = z_q - atan_v;
      end
      idx_d = idx_q + 1'b1;
      if (idx_q == IW'(STAGES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
  end

  assign done_o  = done_q;
  assign angle_o = zero_q ? 33'sd0 : z_q;

endmodule

// ===== hdl/tce_div.sv =====
// Restoring divider, one quotient bit per cycle, rounding to nearest with ties away from zero.
module tce_div
  import tce_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0]        den_i,
  output logic                        done_o,
  output logic signed [DIV_NUM_W-1:0] quot_o
);

  localparam int CW = $clog2(DIV_NUM_W);

  logic [DIV_NUM_W-1:0]        acc_q, acc_d, mag;
  logic signed [DIV_NUM_W-1:0] num_q, num_d;
  logic [DIV_DEN_W-1:0]        den_q, den_d, rem_q, rem_d;
  logic [DIV_DEN_W:0]          rem_sh;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic                        busy_q, busy_d, done_q, done_d, neg_q, neg_d;

  always_comb begin
    mag    = (num_i < 0) ? DIV_NUM_W'(-num_i) : DIV_NUM_W'(num_i);
    rem_sh = {rem_q, acc_q[DIV_NUM_W-1]};
    acc_d  = acc_q;
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = mag + DIV_NUM_W'(den_i >> 1);
      rem_d  = '0;
      num_d  = num_i;
      den_d  = den_i;
      neg_d  = (num_i < 0);
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = DIV_DEN_W'(rem_sh - {1'b0, den_q});
        acc_d = {acc_q[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DIV_DEN_W-1:0];
        acc_d = {acc_q[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DIV_NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // a zero divisor passes the numerator through
  assign done_o = done_q;
  assign quot_o = (den_q == '0) ? num_q :
                  neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule

// ===== hdl/tce_mul.sv =====
// Shared signed multiplier with registered product; product holds until the next issue.
module tce_mul
  import tce_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

// ===== hdl/tilt_complementary_estimator_unit.sv =====
// Tilt estimator top level: one IMU sample in, one pitch/encoder result out. Once calibration
// is done, a sample's result passes through ST_CORDIC, ST_CORR, ST_STEP, ST_FUSE and
// ST_FINISH after it is accepted, and the input is ready again once the sequencer returns to
// ST_IDLE. Most of that is the iterative CORDIC, which resolves one micro-rotation per cycle;
// the shared multiplier is used in ST_CORR, ST_STEP and ST_FUSE after it. During calibration
// each sample also runs ST_CAL_MUL, ST_CAL_DIV and two passes through the bit-serial divider
// that updates the running means. A stalled output holds the sequencer in ST_FINISH.
// The input side is ready only while the sequencer is idle; a finished result waits in the
// output register while the next sample is taken. Configuration writes are always ready and
// should be issued only while the unit is idle.
module tilt_complementary_estimator_unit
  import tce_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // accel_x, accel_z, gyro_y, wheel1_count, wheel2_count
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pitch_fused, pitch_step, accelerometer pitch, pitch_integrated, rate_offset_out,
  // wheel1_pos, wheel1_delta, wheel2_pos, wheel2_delta
  output logic [287:0] m_axis_tdata,
  // estimate_valid
  output logic [0:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  seq_state_e state_q, state_d;

  logic [31:0] gyro_scale_q, sample_period_q;
  logic [15:0] fuse_weight_q;
  logic [9:0]  calib_samples_q;
  logic [7:0]  velocity_window_q;

  logic [COUNT_WIDTH-1:0] c1_q, c2_q;
  logic signed [31:0]     rate_q, rate_off_q, angle_off_q, fused_q, step_q, accel_q;
  logic signed [32:0]     raw_q;
  logic [31:0]            gyro_angle_q;
  logic [9:0]             n_q, calib_count_q;
  logic                   calibrated_q;
  logic [7:0]             window_left_q;
  logic [COUNT_WIDTH-1:0] w1_prev_q, w2_prev_q, w1_diff_q, w2_diff_q;
  logic signed [PROD_W-1:0] acc_q;

  logic [287:0] out_data_q;
  logic         out_user_q, out_valid_q;

  logic in_acc, out_free;
  logic signed [15:0] in_ax, in_az, in_gy;

  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  logic               cor_start, cor_done;
  logic signed [32:0] cor_angle;

  logic                        div_start, div_done;
  logic signed [DIV_NUM_W-1:0] div_num, div_quot;
  logic signed [31:0]          div_sat;

  logic signed [31:0] corr, step_d, fused_d;
  logic [7:0]             wl_d;
  logic [COUNT_WIDTH-1:0] w1_diff_d, w2_diff_d;

  assign in_ax  = $signed(s_axis_tdata[15:0]);
  assign in_az  = $signed(s_axis_tdata[31:16]);
  assign in_gy  = $signed(s_axis_tdata[47:32]);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  assign cor_start = in_acc;
  assign div_sat   = sat32(PROD_W'(div_quot));
  assign corr      = sat32(PROD_W'(rate_q) - PROD_W'(rate_off_q));
  assign step_d    = sat32((prod + (PROD_W'(1) <<< 27)) >>> 28);
  assign fused_d   = sat32((acc_q + prod + PROD_W'(32768)) >>> 16);

  tce_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .y_i     (-(17'(in_ax))),
    .x_i     (-(17'(in_az))),
    .done_o  (cor_done),
    .angle_o (cor_angle)
  );

  tce_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (n_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  tce_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // sequencer: next state, unit issue and operand selection
  always_comb begin
    state_d   = state_q;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = DIV_NUM_W'(prod) + DIV_NUM_W'(rate_q);
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mul_en  = 1'b1;
          mul_a   = MUL_W'(in_gy);
          mul_b   = $signed({2'b00, gyro_scale_q});
          state_d = ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (cor_done) begin
          state_d = calibrated_q ? ST_CORR : ST_CAL_MUL;
        end
      end
      ST_CAL_MUL: begin
        mul_en  = 1'b1;
        mul_a   = $signed({24'd0, n_q - 10'd1});
        mul_b   = MUL_W'(rate_off_q);
        state_d = ST_CAL_DIV;
      end
      ST_CAL_DIV: begin
        div_start = 1'b1;
        mul_en    = 1'b1;
        mul_a     = $signed({24'd0, n_q - 10'd1});
        mul_b     = MUL_W'(angle_off_q);
        state_d   = ST_CAL_WAIT1;
      end
      ST_CAL_WAIT1: begin
        div_num = DIV_NUM_W'(prod) + DIV_NUM_W'(raw_q);
        if (div_done) begin
          div_start = 1'b1;
          state_d   = ST_CAL_WAIT2;
        end
      end
      ST_CAL_WAIT2: begin
        if (div_done) begin
          state_d = ST_CORR;
        end
      end
      ST_CORR: begin
        mul_en  = 1'b1;
        mul_a   = -(MUL_W'(corr));
        mul_b   = $signed({2'b00, sample_period_q});
        state_d = ST_STEP;
      end
      ST_STEP: begin
        mul_en  = 1'b1;
        mul_a   = $signed({18'd0, fuse_weight_q});
        mul_b   = MUL_W'(fused_q) + MUL_W'(step_d);
        state_d = ST_FUSE;
      end
      ST_FUSE: begin
        mul_en  = 1'b1;
        mul_a   = $signed({17'd0, 17'(17'h10000 - {1'b0, fuse_weight_q})});
        mul_b   = MUL_W'(accel_q);
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // encoder window: latch count changes when the countdown wraps to zero
  always_comb begin
    wl_d      = window_left_q - 8'd1;
    w1_diff_d = w1_diff_q;
    w2_diff_d = w2_diff_q;
    if (wl_d == 8'd0) begin
      w1_diff_d = c1_q - w1_prev_q;
      w2_diff_d = c2_q - w2_prev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_scale_q      <= GYRO_SCALE_RST;
      sample_period_q   <= SAMPLE_PERIOD_RST;
      fuse_weight_q     <= FUSE_WEIGHT_RST;
      calib_samples_q   <= CALIB_SAMPLES_RST;
      velocity_window_q <= VELOCITY_WINDOW_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_GYRO_SCALE:      gyro_scale_q      <= cfg_data_i;
        REG_SAMPLE_PERIOD:   sample_period_q   <= cfg_data_i;
        REG_FUSE_WEIGHT:     fuse_weight_q     <= cfg_data_i[15:0];
        REG_CALIB_SAMPLES:   calib_samples_q   <= cfg_data_i[9:0];
        REG_VELOCITY_WINDOW: velocity_window_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // estimator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_off_q    <= '0;
      angle_off_q   <= '0;
      calib_count_q <= '0;
      calibrated_q  <= 1'b0;
      gyro_angle_q  <= '0;
      fused_q       <= '0;
      window_left_q <= VELOCITY_WINDOW_RST;
      w1_prev_q     <= '0;
      w2_prev_q     <= '0;
      w1_diff_q     <= '0;
      w2_diff_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (state_q == ST_CAL_WAIT1 && div_done) begin
        rate_off_q <= div_sat;
      end
      if (state_q == ST_CAL_WAIT2 && div_done) begin
        angle_off_q   <= div_sat;
        calib_count_q <= n_q;
        calibrated_q  <= (n_q == 10'd0) || (n_q >= calib_samples_q);
      end
      if (state_q == ST_STEP) begin
        gyro_angle_q <= gyro_angle_q + step_d;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_FINISH && out_free) begin
        fused_q       <= fused_d;
        window_left_q <= (wl_d == 8'd0) ? velocity_window_q : wl_d;
        w1_diff_q     <= w1_diff_d;
        w2_diff_q     <= w2_diff_d;
        if (wl_d == 8'd0) begin
          w1_prev_q <= c1_q;
          w2_prev_q <= c2_q;
        end
        out_valid_q <= 1'b1;
      end
    end
  end

  // datapath holding registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      c1_q <= s_axis_tdata[48 +: COUNT_WIDTH];
      c2_q <= s_axis_tdata[80 +: COUNT_WIDTH];
      n_q  <= calib_count_q + 10'd1;
    end
    if (state_q == ST_CORDIC) begin
      rate_q <= sat32((prod + PROD_W'(128)) >>> 8);
      raw_q  <= cor_angle;
    end
    if (state_q == ST_STEP) begin
      step_q  <= step_d;
      accel_q <= sat32(PROD_W'(raw_q) - PROD_W'(angle_off_q));
    end
    if (state_q == ST_FUSE) begin
      acc_q <= prod;
    end
    if (state_q == ST_FINISH && out_free) begin
      out_data_q <= {32'($signed(w2_diff_d)), 32'($signed(c2_q)),
                     32'($signed(w1_diff_d)), 32'($signed(c1_q)),
                     rate_off_q, gyro_angle_q, accel_q, step_q, fused_d};
      out_user_q <= calibrated_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ===== hdl/tce_checker.sv =====
// Port-level checker for the tilt estimator, bound to the top level.
`include "tilt_complementary_estimator_unit_assert.svh"

module tce_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [287:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser
);

  logic [1:0] pending_q;
  logic       seen_valid_q;

  // count samples accepted whose results are not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q    <= '0;
      seen_valid_q <= 1'b0;
    end else begin
      pending_q <= pending_q + {1'b0, s_axis_tvalid && s_axis_tready}
                             - {1'b0, m_axis_tvalid && m_axis_tready};
      if (m_axis_tvalid && m_axis_tready && m_axis_tuser[0]) begin
        seen_valid_q <= 1'b1;
      end
    end
  end

  `TCE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata))
  `TCE_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
                  !s_axis_tready)
  `TCE_ASSERT_IMP(a_no_invented, clk_i, rst_ni, m_axis_tvalid, pending_q != 2'd0)
  `TCE_ASSERT_IMP(a_calib_sticky, clk_i, rst_ni, m_axis_tvalid && seen_valid_q,
                  m_axis_tuser[0])

endmodule

bind tilt_complementary_estimator_unit tce_checker u_tce_checker (.*);
